[rtl/core/mpm_pkg.sv]
// shared types and codes for the multi-pattern presence matcher
package mpm_pkg;

  typedef enum logic [2:0] {
    OP_CLEAR    = 3'd0,
    OP_PAT_SYM  = 3'd1,
    OP_PAT_END  = 3'd2,
    OP_BUILD    = 3'd3,
    OP_TEXT_SYM = 3'd4,
    OP_REPORT   = 3'd5
  } opcode_e;

  // which operation a child lookup reports back to
  typedef enum logic [1:0] {
    CTX_INS = 2'd0,
    CTX_TXT = 2'd1,
    CTX_BLD = 2'd2
  } ctx_e;

  typedef enum logic [19:0] {
    S_IDLE    = 20'h00001,
    S_CH_RD   = 20'h00002,
    S_CH_VAL  = 20'h00004,
    S_CH_CHK  = 20'h00008,
    S_INS_CLR = 20'h00010,
    S_FOLLOW  = 20'h00020,
    S_BF_LIST = 20'h00040,
    S_BF_SIBW = 20'h00080,
    S_BF_NEXT = 20'h00100,
    S_BF_POPW = 20'h00200,
    S_BF_FCW  = 20'h00400,
    S_FL_PAR  = 20'h00800,
    S_FL_PARW = 20'h01000,
    S_SP_RD   = 20'h02000,
    S_SP_V    = 20'h04000,
    S_SP_W    = 20'h08000,
    S_RP_RD   = 20'h10000,
    S_RP_E    = 20'h20000,
    S_RP_M    = 20'h40000,
    S_RP_OUT  = 20'h80000
  } state_e;

  localparam int unsigned IDX_W = 6;

endpackage

[rtl/core/multi_pattern_presence_matcher_unit.sv]
// aho-corasick multi-pattern presence matcher, memory based
//
// usage: one input stream carries commands, the kind in tuser (clear, pattern
// symbol, pattern end, build, text symbol, report) and the symbol in tdata.
// report answers with one transfer per loaded pattern on the output stream,
// in load order, tlast on the final one; no other command gives a result.
// the trie lives in a child memory indexed by node and symbol; an entry is
// trusted only if it points below the node count and the target's stored
// parent and symbol agree, so clear only resets the counters and cursors and no sweep is needed.
// every command is taken only while the unit is idle (one at a time).
// clear and pattern end finish in idle; pattern symbol and text symbol each
// do a child lookup, and text symbol one more lookup per failure link followed.
// build walks the trie breadth first over sibling lists, with one lookup per
// failure step for each node. report walks the trie the same way, then spreads
// marks deepest node first and sends one result per pattern; the single read
// port of each memory sets the pace of these steps.
// reset: empty trie (root only), no patterns, cursors at the root.
// an output stall simply holds the pending result; no input is taken then.
module multi_pattern_presence_matcher_unit #(
  parameter int unsigned MAX_NODES    = 1024,
  parameter int unsigned MAX_PATTERNS = 64,
  parameter int unsigned SYMBOL_BITS  = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] symbol
  input  logic [2:0] s_axis_tuser_i,   // [2:0] opcode
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [5:0] pattern_index, [6] found, [7] table_full
  output logic       m_axis_tlast_o    // last
);
  import mpm_pkg::*;

  localparam int unsigned NB     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned NCW    = $clog2(MAX_NODES + 1);
  localparam int unsigned SB     = SYMBOL_BITS;
  localparam int unsigned PB     = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int unsigned PCW    = $clog2(MAX_PATTERNS + 1);
  localparam int unsigned CDEPTH = MAX_NODES * (2 ** SB);

  typedef struct packed {
    logic [NB-1:0] parent;
    logic [SB-1:0] sym;
    logic [NB-1:0] nsib;
  } link_t;

  // memories
  logic [NB-1:0] child_mem [CDEPTH];
  logic [NB-1:0] fail_mem  [MAX_NODES];
  link_t         link_mem  [MAX_NODES];
  logic [NB-1:0] fc_mem    [MAX_NODES];
  logic          mark_mem  [MAX_NODES];
  logic [NB-1:0] bfs_mem   [MAX_NODES];
  logic [NB-1:0] pend_mem  [MAX_PATTERNS];

  logic             child_we;
  logic [NB+SB-1:0] child_ra, child_wa;
  logic [NB-1:0]    child_wd, child_rd_q;
  logic             fail_we;
  logic [NB-1:0]    fail_ra, fail_wa, fail_wd, fail_rd_q;
  logic             link_we;
  logic [NB-1:0]    link_ra, link_wa;
  link_t            link_wd, link_rd_q;
  logic             fc_we;
  logic [NB-1:0]    fc_ra, fc_wa, fc_wd, fc_rd_q;
  logic             mark_we, mark_wd, mark_rd_q;
  logic [NB-1:0]    mark_ra, mark_wa;
  logic             bfs_we;
  logic [NB-1:0]    bfs_ra, bfs_wa, bfs_wd, bfs_rd_q;
  logic             pend_we;
  logic [PB-1:0]    pend_ra, pend_wa;
  logic [NB-1:0]    pend_wd, pend_rd_q;

  always_ff @(posedge clk_i) begin
    if (child_we) child_mem[child_wa] <= child_wd;
    child_rd_q <= child_mem[child_ra];
  end
  always_ff @(posedge clk_i) begin
    if (fail_we) fail_mem[fail_wa] <= fail_wd;
    fail_rd_q <= fail_mem[fail_ra];
  end
  always_ff @(posedge clk_i) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    link_rd_q <= link_mem[link_ra];
  end
  always_ff @(posedge clk_i) begin
    if (fc_we) fc_mem[fc_wa] <= fc_wd;
    fc_rd_q <= fc_mem[fc_ra];
  end
  always_ff @(posedge clk_i) begin
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    mark_rd_q <= mark_mem[mark_ra];
  end
  always_ff @(posedge clk_i) begin
    if (bfs_we) bfs_mem[bfs_wa] <= bfs_wd;
    bfs_rd_q <= bfs_mem[bfs_ra];
  end
  always_ff @(posedge clk_i) begin
    if (pend_we) pend_mem[pend_wa] <= pend_wd;
    pend_rd_q <= pend_mem[pend_ra];
  end

  // control state
  state_e         state_q, state_d;
  ctx_e           ctx_q, ctx_d;
  logic [NB-1:0]  lk_node_q, lk_node_d;
  logic [SB-1:0]  lk_sym_q, lk_sym_d;
  logic [NB-1:0]  lk_child_q, lk_child_d;
  logic [NB-1:0]  fc_old_q, fc_old_d;
  logic [NB-1:0]  new_q, new_d;
  logic [NB-1:0]  ins_cur_q, ins_cur_d;
  logic [NB-1:0]  match_q, match_d;
  logic [NCW-1:0] node_cnt_q, node_cnt_d;
  logic [PCW-1:0] pat_cnt_q, pat_cnt_d;
  logic           ovf_q, ovf_d;
  logic           root_mark_q, root_mark_d;
  logic [NB-1:0]  root_fc_q, root_fc_d;
  logic           links_q, links_d;
  logic [NB-1:0]  cur_x_q, cur_x_d;
  logic [NB-1:0]  walk_q, walk_d;
  logic [NB-1:0]  head_q, head_d;
  logic [NB-1:0]  tail_q, tail_d;
  logic [NB-1:0]  idx_q, idx_d;
  logic [PCW-1:0] pidx_q, pidx_d;
  logic           out_vld_q, out_vld_d;
  logic [IDX_W-1:0] out_idx_q, out_idx_d;
  logic           out_found_q, out_found_d;
  logic           out_full_q, out_full_d;
  logic           out_last_q, out_last_d;

  logic          in_xfer;
  opcode_e       in_op;
  logic          cand;
  logic          res_en, res_hit;
  logic [NB-1:0] fc_prev;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign in_op           = opcode_e'(s_axis_tuser_i);

  // child entry points at a live node
  assign cand    = (child_rd_q != '0) && (NCW'(child_rd_q) < node_cnt_q);
  assign res_en  = ((state_q == S_CH_VAL) && !cand) || (state_q == S_CH_CHK);
  assign res_hit = (state_q == S_CH_CHK) && (link_rd_q.parent == lk_node_q) &&
                   (link_rd_q.sym == lk_sym_q);
  assign fc_prev = (state_q == S_CH_VAL) ?
                   ((lk_node_q == '0) ? root_fc_q : fc_rd_q) : fc_old_q;

  always_comb begin
    state_d     = state_q;
    ctx_d       = ctx_q;
    lk_node_d   = lk_node_q;
    lk_sym_d    = lk_sym_q;
    lk_child_d  = lk_child_q;
    fc_old_d    = fc_old_q;
    new_d       = new_q;
    ins_cur_d   = ins_cur_q;
    match_d     = match_q;
    node_cnt_d  = node_cnt_q;
    pat_cnt_d   = pat_cnt_q;
    ovf_d       = ovf_q;
    root_mark_d = root_mark_q;
    root_fc_d   = root_fc_q;
    links_d     = links_q;
    cur_x_d     = cur_x_q;
    walk_d      = walk_q;
    head_d      = head_q;
    tail_d      = tail_q;
    idx_d       = idx_q;
    pidx_d      = pidx_q;
    out_vld_d   = out_vld_q;
    out_idx_d   = out_idx_q;
    out_found_d = out_found_q;
    out_full_d  = out_full_q;
    out_last_d  = out_last_q;

    child_we = 1'b0;
    child_ra = {lk_node_q, lk_sym_q};
    child_wa = {lk_node_q, lk_sym_q};
    child_wd = node_cnt_q[NB-1:0];
    fail_we  = 1'b0;
    fail_ra  = lk_node_q;
    fail_wa  = cur_x_q;
    fail_wd  = '0;
    link_we  = 1'b0;
    link_ra  = cur_x_q;
    link_wa  = node_cnt_q[NB-1:0];
    link_wd  = '{parent: lk_node_q, sym: lk_sym_q, nsib: fc_prev};
    fc_we    = 1'b0;
    fc_ra    = lk_node_q;
    fc_wa    = lk_node_q;
    fc_wd    = node_cnt_q[NB-1:0];
    mark_we  = 1'b0;
    mark_ra  = pend_rd_q;
    mark_wa  = node_cnt_q[NB-1:0];
    mark_wd  = 1'b0;
    bfs_we   = 1'b0;
    bfs_ra   = head_q;
    bfs_wa   = tail_q;
    bfs_wd   = walk_q;
    pend_we  = 1'b0;
    pend_ra  = pidx_q[PB-1:0];
    pend_wa  = pat_cnt_q[PB-1:0];
    pend_wd  = ins_cur_q;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          lk_sym_d = s_axis_tdata_i[SB-1:0];
          case (in_op)
            OP_CLEAR: begin
              node_cnt_d  = NCW'(1);
              pat_cnt_d   = '0;
              ins_cur_d   = '0;
              match_d     = '0;
              ovf_d       = 1'b0;
              root_mark_d = 1'b0;
              root_fc_d   = '0;
            end
            OP_PAT_SYM: begin
              ctx_d     = CTX_INS;
              lk_node_d = ins_cur_q;
              state_d   = S_CH_RD;
            end
            OP_PAT_END: begin
              if (pat_cnt_q < PCW'(MAX_PATTERNS)) begin
                pend_we   = 1'b1;
                pat_cnt_d = pat_cnt_q + 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
              ins_cur_d = '0;
            end
            OP_BUILD, OP_REPORT: begin
              links_d = (in_op == OP_BUILD);
              cur_x_d = '0;
              walk_d  = root_fc_q;
              head_d  = '0;
              tail_d  = '0;
              state_d = S_BF_LIST;
            end
            OP_TEXT_SYM: begin
              ctx_d     = CTX_TXT;
              lk_node_d = match_q;
              state_d   = S_CH_RD;
            end
            default: ;
          endcase
        end
      end
      S_CH_RD: state_d = S_CH_VAL;
      S_CH_VAL: begin
        fc_old_d = fc_prev;
        if (cand) begin
          link_ra    = child_rd_q;
          lk_child_d = child_rd_q;
          state_d    = S_CH_CHK;
        end
      end
      S_CH_CHK: ;
      S_INS_CLR: begin
        fc_we   = 1'b1;
        fc_wa   = new_q;
        fc_wd   = '0;
        state_d = S_IDLE;
      end
      S_FOLLOW: begin
        lk_node_d = fail_rd_q;
        state_d   = S_CH_RD;
      end
      S_BF_LIST: begin
        if (walk_q == '0) begin
          if (links_q && (cur_x_q != '0)) state_d = S_FL_PAR;
          else state_d = S_BF_NEXT;
        end else begin
          bfs_we  = 1'b1;
          tail_d  = tail_q + 1'b1;
          link_ra = walk_q;
          state_d = S_BF_SIBW;
        end
      end
      S_BF_SIBW: begin
        walk_d  = link_rd_q.nsib;
        state_d = S_BF_LIST;
      end
      S_BF_NEXT: begin
        if (head_q == tail_q) begin
          if (links_q) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = tail_q;
            state_d = S_SP_RD;
          end
        end else begin
          head_d  = head_q + 1'b1;
          state_d = S_BF_POPW;
        end
      end
      S_BF_POPW: begin
        cur_x_d = bfs_rd_q;
        fc_ra   = bfs_rd_q;
        state_d = S_BF_FCW;
      end
      S_BF_FCW: begin
        walk_d  = fc_rd_q;
        state_d = S_BF_LIST;
      end
      S_FL_PAR: state_d = S_FL_PARW;
      S_FL_PARW: begin
        if (link_rd_q.parent == '0) begin
          fail_we = 1'b1;
          state_d = S_BF_NEXT;
        end else begin
          ctx_d    = CTX_BLD;
          lk_sym_d = link_rd_q.sym;
          fail_ra  = link_rd_q.parent;
          state_d  = S_FOLLOW;
        end
      end
      S_SP_RD: begin
        if (idx_q == '0) begin
          pidx_d  = '0;
          state_d = S_RP_RD;
        end else begin
          bfs_ra  = idx_q - 1'b1;
          idx_d   = idx_q - 1'b1;
          state_d = S_SP_V;
        end
      end
      S_SP_V: begin
        mark_ra = bfs_rd_q;
        fail_ra = bfs_rd_q;
        state_d = S_SP_W;
      end
      S_SP_W: begin
        if (mark_rd_q) begin
          if (fail_rd_q == '0) begin
            root_mark_d = 1'b1;
          end else begin
            mark_we = 1'b1;
            mark_wa = fail_rd_q;
            mark_wd = 1'b1;
          end
        end
        state_d = S_SP_RD;
      end
      S_RP_RD: begin
        if (pidx_q == pat_cnt_q) state_d = S_IDLE;
        else state_d = S_RP_E;
      end
      S_RP_E: state_d = S_RP_M;
      S_RP_M: begin
        out_vld_d   = 1'b1;
        out_idx_d   = IDX_W'(pidx_q);
        out_found_d = (pend_rd_q == '0) ? root_mark_q : mark_rd_q;
        out_full_d  = ovf_q;
        out_last_d  = ((pidx_q + 1'b1) == pat_cnt_q);
        state_d     = S_RP_OUT;
      end
      S_RP_OUT: begin
        if (m_axis_tready_i) begin
          out_vld_d = 1'b0;
          pidx_d    = pidx_q + 1'b1;
          state_d   = S_RP_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // outcome of a child lookup
    if (res_en) begin
      case (ctx_q)
        CTX_INS: begin
          state_d = S_IDLE;
          if (res_hit) begin
            ins_cur_d = lk_child_q;
          end else if (node_cnt_q < NCW'(MAX_NODES)) begin
            link_we  = 1'b1;
            fail_we  = 1'b1;
            fail_wa  = node_cnt_q[NB-1:0];
            mark_we  = 1'b1;
            child_we = 1'b1;
            if (lk_node_q == '0) root_fc_d = node_cnt_q[NB-1:0];
            else fc_we = 1'b1;
            new_d      = node_cnt_q[NB-1:0];
            ins_cur_d  = node_cnt_q[NB-1:0];
            node_cnt_d = node_cnt_q + 1'b1;
            state_d    = S_INS_CLR;
          end else begin
            ovf_d = 1'b1;
          end
        end
        CTX_TXT: begin
          if (res_hit) begin
            match_d = lk_child_q;
            mark_we = 1'b1;
            mark_wa = lk_child_q;
            mark_wd = 1'b1;
            state_d = S_IDLE;
          end else if (lk_node_q == '0) begin
            match_d     = '0;
            root_mark_d = 1'b1;
            state_d     = S_IDLE;
          end else begin
            state_d = S_FOLLOW;
          end
        end
        CTX_BLD: begin
          if (res_hit) begin
            fail_we = 1'b1;
            fail_wd = lk_child_q;
            state_d = S_BF_NEXT;
          end else if (lk_node_q == '0) begin
            fail_we = 1'b1;
            state_d = S_BF_NEXT;
          end else begin
            state_d = S_FOLLOW;
          end
        end
        default: state_d = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ctx_q       <= CTX_INS;
      ins_cur_q   <= '0;
      match_q     <= '0;
      node_cnt_q  <= NCW'(1);
      pat_cnt_q   <= '0;
      ovf_q       <= 1'b0;
      root_mark_q <= 1'b0;
      root_fc_q   <= '0;
      links_q     <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      idx_q       <= '0;
      pidx_q      <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      ctx_q       <= ctx_d;
      ins_cur_q   <= ins_cur_d;
      match_q     <= match_d;
      node_cnt_q  <= node_cnt_d;
      pat_cnt_q   <= pat_cnt_d;
      ovf_q       <= ovf_d;
      root_mark_q <= root_mark_d;
      root_fc_q   <= root_fc_d;
      links_q     <= links_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      idx_q       <= idx_d;
      pidx_q      <= pidx_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lk_node_q   <= lk_node_d;
    lk_sym_q    <= lk_sym_d;
    lk_child_q  <= lk_child_d;
    fc_old_q    <= fc_old_d;
    new_q       <= new_d;
    cur_x_q     <= cur_x_d;
    walk_q      <= walk_d;
    out_idx_q   <= out_idx_d;
    out_found_q <= out_found_d;
    out_full_q  <= out_full_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {out_full_q, out_found_q, out_idx_q};
  assign m_axis_tlast_o  = out_last_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state register not one-hot");

  a_out_only_in_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (state_q == S_RP_OUT)) else $error("result outside report");

  a_no_input_while_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o) else $error("input taken with result pending");

  a_node_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (node_cnt_q != '0) && (node_cnt_q <= NCW'(MAX_NODES)))
    else $error("node count out of range");

  a_pat_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pat_cnt_q <= PCW'(MAX_PATTERNS)) else $error("pattern count out of range");

endmodule

[tb/mpm_checker.sv]
// checker for the presence matcher: predicts report results and compares them
module mpm_checker
  import mpm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  input  logic       s_axis_tready_i,
  input  logic [7:0] s_axis_tdata_i,
  input  logic [2:0] s_axis_tuser_i,
  input  logic       m_axis_tvalid_i,
  input  logic       m_axis_tready_i,
  input  logic [7:0] m_axis_tdata_i,
  input  logic       m_axis_tlast_i,
  output int         errors_o,
  output int         pending_o,
  output int         results_o,
  output int         overflow_seen_o
);

  localparam int unsigned NODES = 1024;
  localparam int unsigned PATS  = 64;

  typedef struct packed {
    logic [5:0] pattern_index;
    logic       found;
    logic       table_full;
    logic       last;
  } verdict_t;

  // trie kept sparse so that clear is cheap
  int unsigned trie_kid[int unsigned];
  logic [9:0]  fail_of[NODES];
  logic [9:0]  parent_of[NODES];
  logic [7:0]  sym_of[NODES];
  logic [9:0]  walk_order[NODES];
  bit          reached[NODES];
  logic [9:0]  pat_node[PATS];
  int unsigned n_nodes, n_pats;
  logic [9:0]  ins_cur, txt_cur;
  bit          full_flag;
  verdict_t    verdicts_due[$];

  function automatic int unsigned kid(int unsigned node, int unsigned s);
    int unsigned key;
    key = node * 256 + s;
    return trie_kid.exists(key) ? trie_kid[key] : 0;
  endfunction

  function automatic void wipe();
    trie_kid.delete();
    foreach (reached[i]) reached[i] = 1'b0;
    n_nodes = 1;
    n_pats = 0;
    ins_cur = '0;
    txt_cur = '0;
    full_flag = 1'b0;
  endfunction

  function automatic int unsigned breadth_walk(bit link);
    int unsigned head, tail, x, c, f;
    head = 0;
    tail = 0;
    for (int s = 0; s < 256; s++) begin
      c = kid(0, s);
      if (c != 0 && tail < NODES) begin
        walk_order[tail] = c;
        tail++;
      end
    end
    while (head < tail) begin
      x = walk_order[head];
      head++;
      for (int s = 0; s < 256; s++) begin
        c = kid(x, s);
        if (c != 0 && tail < NODES) begin
          walk_order[tail] = c;
          tail++;
        end
      end
      if (link) begin
        f = 0;
        if (parent_of[x] != 0) begin
          f = fail_of[parent_of[x]];
          while (f != 0 && kid(f, sym_of[x]) == 0) f = fail_of[f];
          if (kid(f, sym_of[x]) != 0) f = kid(f, sym_of[x]);
        end
        fail_of[x] = f;
      end
    end
    return tail;
  endfunction

  function automatic void apply_command(logic [2:0] op, logic [7:0] s);
    int unsigned c, cnt, pos;
    verdict_t v;
    case (op)
      OP_CLEAR: wipe();
      OP_PAT_SYM: begin
        c = kid(ins_cur, s);
        if (c != 0) begin
          ins_cur = c;
        end else if (n_nodes < NODES) begin
          parent_of[n_nodes] = ins_cur;
          sym_of[n_nodes] = s;
          fail_of[n_nodes] = '0;
          reached[n_nodes] = 1'b0;
          trie_kid[ins_cur * 256 + s] = n_nodes;
          ins_cur = n_nodes;
          n_nodes++;
        end else begin
          full_flag = 1'b1;
        end
      end
      OP_PAT_END: begin
        if (n_pats < PATS) begin
          pat_node[n_pats] = ins_cur;
          n_pats++;
        end else begin
          full_flag = 1'b1;
        end
        ins_cur = '0;
      end
      OP_BUILD: begin
        fail_of[0] = '0;
        void'(breadth_walk(1'b1));
      end
      OP_TEXT_SYM: begin
        pos = txt_cur;
        while (pos != 0 && kid(pos, s) == 0) pos = fail_of[pos];
        if (kid(pos, s) != 0) pos = kid(pos, s);
        reached[pos] = 1'b1;
        txt_cur = pos;
      end
      OP_REPORT: begin
        cnt = breadth_walk(1'b0);
        // spread marks toward shorter suffixes, deepest nodes first
        while (cnt > 0) begin
          cnt--;
          if (reached[walk_order[cnt]]) reached[fail_of[walk_order[cnt]]] = 1'b1;
        end
        for (int unsigned i = 0; i < n_pats; i++) begin
          v.pattern_index = i[5:0];
          v.found = reached[pat_node[i]];
          v.table_full = full_flag;
          v.last = (i + 1 == n_pats);
          verdicts_due.push_back(v);
        end
        if (full_flag) overflow_seen_o++;
      end
      default: ;
    endcase
  endfunction

  initial begin
    errors_o = 0;
    results_o = 0;
    overflow_seen_o = 0;
    wipe();
  end

  always_comb pending_o = verdicts_due.size();

  always @(posedge clk_i) begin
    verdict_t got, want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i) apply_command(s_axis_tuser_i, s_axis_tdata_i);
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = {m_axis_tdata_i[5:0], m_axis_tdata_i[6], m_axis_tdata_i[7], m_axis_tlast_i};
        results_o++;
        if (verdicts_due.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected result transfer, actual %h", $time, got);
        end else begin
          want = verdicts_due.pop_front();
          if (got.pattern_index !== want.pattern_index) begin
            errors_o++;
            $display("%0t: pattern_index expected %0d actual %0d", $time,
                     want.pattern_index, got.pattern_index);
          end
          if (got.found !== want.found) begin
            errors_o++;
            $display("%0t: found (pattern %0d) expected %0b actual %0b", $time,
                     want.pattern_index, want.found, got.found);
          end
          if (got.table_full !== want.table_full) begin
            errors_o++;
            $display("%0t: table_full expected %0b actual %0b", $time,
                     want.table_full, got.table_full);
          end
          if (got.last !== want.last) begin
            errors_o++;
            $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
          end
        end
      end
    end
  end

endmodule

[tb/tb_multi_pattern_presence_matcher_unit.sv]
// testbench top for the presence matcher: stimulus, flow control and verdict
module tb_multi_pattern_presence_matcher_unit;
  import mpm_pkg::*;

  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i = '0;   // [7:0] symbol
  logic [2:0] s_axis_tuser_i = '0;   // [2:0] opcode
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;        // [5:0] pattern_index, [6] found, [7] table_full
  logic       m_axis_tlast_o;

  int errors, pending, results, overflow_reports;
  int idle_pct_tx = 0, stall_pct_rx = 0;
  int hold_cycles = 0;
  int sent = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  multi_pattern_presence_matcher_unit i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tlast_o
  );

  mpm_checker i_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o),
    .m_axis_tlast_i(m_axis_tlast_o),
    .errors_o(errors), .pending_o(pending), .results_o(results),
    .overflow_seen_o(overflow_reports)
  );

  // receiver: random stalls, or a long counted hold-off when requested
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      m_axis_tready_i <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= stall_pct_rx);
    end
  end

  task automatic send(logic [2:0] op, logic [7:0] sym);
    bit taken;
    while ($urandom_range(99) < idle_pct_tx) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= op;
    s_axis_tdata_i <= sym;
    do begin
      @(negedge clk_i);
      taken = s_axis_tready_o;
      @(posedge clk_i);
    end while (!taken);
    if (op != OP_SPARE_A && op != OP_SPARE_B) sent++;
  endtask

  task automatic load_pattern(int len, int alpha);
    for (int i = 0; i < len; i++) send(OP_PAT_SYM, 8'($urandom_range(alpha - 1)));
    send(OP_PAT_END, 8'($urandom));
  endtask

  task automatic feed_text(int len, int alpha);
    for (int i = 0; i < len; i++) send(OP_TEXT_SYM, 8'($urandom_range(alpha - 1)));
  endtask

  task automatic set_phase(int ph);
    case (ph)
      0: begin idle_pct_tx = 0;  stall_pct_rx = 0;  end
      1: begin idle_pct_tx = 62; stall_pct_rx = 0;  end
      2: begin idle_pct_tx = 0;  stall_pct_rx = 62; end
      default: begin idle_pct_tx = 6; stall_pct_rx = 6; end
    endcase
  endtask

  task automatic random_case();
    int alpha, np;
    alpha = ($urandom_range(9) == 0) ? 256 : $urandom_range(2, 4);
    np = $urandom_range(1, 8);
    send(OP_CLEAR, 8'($urandom));
    for (int p = 0; p < np; p++) load_pattern($urandom_range(0, 5), alpha);
    if ($urandom_range(7) != 0) send(OP_BUILD, 8'($urandom));
    feed_text($urandom_range(3, 20), alpha);
    if ($urandom_range(4) == 0) send($urandom_range(1) ? OP_SPARE_A : OP_SPARE_B, 8'($urandom));
    send(OP_REPORT, 8'($urandom));
    if ($urandom_range(2) == 0) begin
      // pattern added after build, then more text and a repeated report
      load_pattern($urandom_range(1, 3), alpha);
      feed_text($urandom_range(1, 8), alpha);
      send(OP_REPORT, 8'($urandom));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty report, empty pattern, extreme symbols, text before build
    send(OP_REPORT, 8'h00);
    send(OP_PAT_END, 8'hff);
    send(OP_PAT_SYM, 8'h00);
    send(OP_PAT_SYM, 8'hff);
    send(OP_PAT_END, 8'h00);
    send(OP_PAT_SYM, 8'hff);
    send(OP_PAT_END, 8'h00);
    send(OP_REPORT, 8'h00);
    send(OP_TEXT_SYM, 8'h00);
    send(OP_TEXT_SYM, 8'hff);
    send(OP_REPORT, 8'h00);
    send(OP_BUILD, 8'h00);
    send(OP_TEXT_SYM, 8'hff);
    send(OP_PAT_SYM, 8'h55);
    send(OP_PAT_SYM, 8'haa);
    send(OP_PAT_END, 8'h00);
    send(OP_TEXT_SYM, 8'h55);
    send(OP_TEXT_SYM, 8'haa);
    send(OP_SPARE_A, 8'h12);
    send(OP_SPARE_B, 8'h34);
    send(OP_REPORT, 8'h00);
    send(OP_REPORT, 8'h00);

    // pattern store overflow: many short patterns, long receiver hold-off
    send(OP_CLEAR, 8'h00);
    for (int i = 0; i < 66; i++) load_pattern(i % 3, 2);
    send(OP_BUILD, 8'h00);
    feed_text(6, 2);
    hold_cycles = 400;
    send(OP_REPORT, 8'h00);
    feed_text(3, 2);
    send(OP_REPORT, 8'h00);
    wait (pending == 0);

    // node store overflow: one long chain that runs past the node limit
    set_phase(3);
    send(OP_CLEAR, 8'h00);
    for (int i = 0; i < 1030; i++) send(OP_PAT_SYM, 8'(i % 256 == 0 ? 1 : i % 256));
    send(OP_PAT_END, 8'h00);
    load_pattern(2, 3);
    send(OP_BUILD, 8'h00);
    feed_text(8, 3);
    send(OP_REPORT, 8'h00);
    wait (pending == 0);

    for (int ph = 0; sent < 1600; ph++) begin
      set_phase(ph % 4);
      for (int k = 0; k < 4; k++) random_case();
    end
    s_axis_tvalid_i <= 1'b0;
    wait (pending == 0);
    repeat (3000) @(posedge clk_i);

    $display("covered %0d commands and %0d report results, %0d reports with table overflow",
             sent, results, overflow_reports);
    $display("phases: free flow, sender gaps, receiver stalls, mixed, long hold-off");
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("timeout");
    $display("status: fail");
    $finish;
  end

endmodule
